// File: src/omt_pkg.sv
// Shared types for the owned mutex table: request operations, result status
// codes and the control word that travels down the row of table cells.
// No dependencies.
package omt_pkg;

	// Width of the mutex number field on the request channel
	localparam int ID_BITS = 8;

	// Request operations; codes match the cmd field of a request
	typedef enum logic [1:0] {
		OP_LOCK    = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CLEANUP = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_DONE        = 3'd0,
		ST_BLOCKED     = 3'd1,
		ST_MALFORMED   = 3'd2,
		ST_REENTRANT   = 3'd3,
		ST_NOT_OWNED   = 3'd4,
		ST_UNSUPPORTED = 3'd5
	} status_t;

	// Control word handed from cell to cell along with the request
	typedef struct packed {
		logic    vld;
		op_t     op;
		status_t status;
	} omt_ctl_t;

endpackage

// File: src/owned_mutex_table.sv
// Owned mutex table: MUTEX_COUNT hardware mutexes, each recording its owner
// as a task handle and dispatch handle pair.
//
// Request channel (s_axis): one request per handshake; tuser carries the
// operation (lock, release, cleanup, unsupported), tdata the mutex number,
// both handles, liveness, byte count and payload flag.
// Result channel (m_axis): one status byte per request.
//
// A request is checked for malformed fields on entry and then walks a row of
// MUTEX_COUNT cells, one cell per cycle; each cell owns one mutex and
// updates it and the status as the request passes; the result register
// follows the last cell. One request is in the row at a time: s_axis_tready
// drops on accept and returns in the cycle after the result is taken, so a
// new request is not taken until the result of the last one has been taken.
// Reset frees every mutex and empties the row. While m_axis_tready is low the
// result holds steady and no new request is taken.
// Depends on omt_pkg and omt_cell.
module owned_mutex_table import omt_pkg::*; #(
	parameter int MUTEX_COUNT = 16,
	parameter int HANDLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mutex_id[7:0], task_handle[39:8], dispatch_handle[71:40],
	// task_live[72], access_bytes[79:73], has_payload[80], zero[87:81]
	input  logic [87:0] s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], zero[7:3]
	output logic [7:0]  m_axis_tdata
);

	localparam int IDX_BITS = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;

	omt_ctl_t               lnk_ctl  [MUTEX_COUNT+1];
	logic [IDX_BITS-1:0]    lnk_id   [MUTEX_COUNT+1];
	logic [HANDLE_BITS-1:0] lnk_task [MUTEX_COUNT+1];
	logic [HANDLE_BITS-1:0] lnk_disp [MUTEX_COUNT+1];

	logic               busy_q;
	logic               out_vld_q;
	status_t            out_status_q;

	logic               acc;
	logic               out_acc;
	op_t                cmd;
	logic [ID_BITS-1:0] id;
	logic               live;
	logic [6:0]         bytes_n;
	logic               payload;
	logic               bad_id;
	logic               malformed;
	omt_ctl_t           entry_ctl;

	// Unpack the request
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign cmd     = op_t'(s_axis_tuser);
	assign id      = s_axis_tdata[7:0];
	assign live    = s_axis_tdata[72];
	assign bytes_n = s_axis_tdata[79:73];
	assign payload = s_axis_tdata[80];

	// Screen malformed requests before they enter the row
	assign bad_id = (cmd == OP_CLEANUP) ? (id != '0)
		: ({1'b0, id} >= (ID_BITS+1)'(MUTEX_COUNT));
	assign malformed = (bytes_n != '0) || payload || !live || bad_id;

	always_comb begin
		entry_ctl.vld = acc;
		if (malformed) begin
			entry_ctl.op     = OP_NONE;
			entry_ctl.status = ST_MALFORMED;
		end else if (cmd == OP_NONE) begin
			entry_ctl.op     = OP_NONE;
			entry_ctl.status = ST_UNSUPPORTED;
		end else begin
			entry_ctl.op     = cmd;
			entry_ctl.status = ST_DONE;
		end
	end

	assign lnk_ctl[0]  = entry_ctl;
	assign lnk_id[0]   = id[IDX_BITS-1:0];
	assign lnk_task[0] = HANDLE_BITS'(s_axis_tdata[39:8]);
	assign lnk_disp[0] = HANDLE_BITS'(s_axis_tdata[71:40]);

	// Row of table cells, one per mutex
	for (genvar gi = 0; gi < MUTEX_COUNT; gi++) begin : g_cell
		omt_cell #(
			.HANDLE_BITS (HANDLE_BITS),
			.IDX_BITS    (IDX_BITS),
			.CELL_INDEX  (gi)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_ctl  (lnk_ctl[gi]),
			.up_id   (lnk_id[gi]),
			.up_task (lnk_task[gi]),
			.up_disp (lnk_disp[gi]),
			.dn_ctl  (lnk_ctl[gi+1]),
			.dn_id   (lnk_id[gi+1]),
			.dn_task (lnk_task[gi+1]),
			.dn_disp (lnk_disp[gi+1])
		);
	end

	// Track the request in flight and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (out_acc) begin
				busy_q <= 1'b0;
			end
			if (lnk_ctl[MUTEX_COUNT].vld) begin
				out_vld_q <= 1'b1;
			end else if (out_acc) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_ctl[MUTEX_COUNT].vld) begin
			out_status_q <= lnk_ctl[MUTEX_COUNT].status;
		end
	end

	assign s_axis_tready = !busy_q;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'b0, out_status_q};

endmodule

// File: src/omt_cell.sv
// One cell of the mutex table: holds the owner of a single mutex, applies the
// passing request to it and hands the request on to the next cell.
// Depends on omt_pkg.
module omt_cell import omt_pkg::*; #(
	parameter int HANDLE_BITS = 32,
	parameter int IDX_BITS    = 4,
	parameter int CELL_INDEX  = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  omt_ctl_t               up_ctl,
	input  logic [IDX_BITS-1:0]    up_id,
	input  logic [HANDLE_BITS-1:0] up_task,
	input  logic [HANDLE_BITS-1:0] up_disp,
	output omt_ctl_t               dn_ctl,
	output logic [IDX_BITS-1:0]    dn_id,
	output logic [HANDLE_BITS-1:0] dn_task,
	output logic [HANDLE_BITS-1:0] dn_disp
);

	logic                   own_vld_q;
	logic [HANDLE_BITS-1:0] own_task_q;
	logic [HANDLE_BITS-1:0] own_disp_q;

	omt_ctl_t               dn_ctl_s1;
	logic [IDX_BITS-1:0]    dn_id_s1;
	logic [HANDLE_BITS-1:0] dn_task_s1;
	logic [HANDLE_BITS-1:0] dn_disp_s1;

	logic    hit;
	logic    tgt;
	logic    take;
	logic    clr;
	status_t nxt_status;

	// Compare the stored owner with the requester
	assign hit = own_vld_q && (own_task_q == up_task) && (own_disp_q == up_disp);
	assign tgt = (up_id == IDX_BITS'(CELL_INDEX));

	// Decide what the request does to this entry
	always_comb begin
		nxt_status = up_ctl.status;
		take       = 1'b0;
		clr        = 1'b0;
		if (up_ctl.vld) begin
			case (up_ctl.op)
				OP_LOCK: begin
					if (tgt) begin
						if (own_vld_q) begin
							nxt_status = hit ? ST_REENTRANT : ST_BLOCKED;
						end else begin
							take = 1'b1;
						end
					end
				end
				OP_RELEASE: begin
					if (tgt) begin
						if (hit) begin
							clr = 1'b1;
						end else begin
							nxt_status = ST_NOT_OWNED;
						end
					end
				end
				OP_CLEANUP: begin
					clr = hit;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the owner valid bit and the forwarded control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_vld_q <= 1'b0;
			dn_ctl_s1 <= '0;
		end else begin
			if (take) begin
				own_vld_q <= 1'b1;
			end else if (clr) begin
				own_vld_q <= 1'b0;
			end
			dn_ctl_s1.vld    <= up_ctl.vld;
			dn_ctl_s1.op     <= up_ctl.op;
			dn_ctl_s1.status <= nxt_status;
		end
	end

	// Hold owner handles and pass the request payload on
	always_ff @(posedge clk) begin
		if (take) begin
			own_task_q <= up_task;
			own_disp_q <= up_disp;
		end else if (clr) begin
			own_task_q <= '0;
			own_disp_q <= '0;
		end
		dn_id_s1   <= up_id;
		dn_task_s1 <= up_task;
		dn_disp_s1 <= up_disp;
	end

	assign dn_ctl  = dn_ctl_s1;
	assign dn_id   = dn_id_s1;
	assign dn_task = dn_task_s1;
	assign dn_disp = dn_disp_s1;

endmodule

// File: src/omt_checker.sv
// Port-level checks for the owned mutex table, attached by bind.
// Depends on omt_pkg and owned_mutex_table's port list.
module omt_checker import omt_pkg::*; #(
	parameter int MUTEX_COUNT = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [87:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Take one request at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while one in flight");

	// Reopen the request side once the result is taken
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
		else $error("request side not reopened after result");

	// Report a payload-carrying request as malformed after the row delay
	a_payload_malformed: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[80]
		|-> ##(MUTEX_COUNT+1) m_axis_tvalid && (m_axis_tdata == {5'b0, ST_MALFORMED}))
		else $error("payload request not reported malformed");

endmodule

bind owned_mutex_table omt_checker #(.MUTEX_COUNT(MUTEX_COUNT)) u_omt_checker (.*);

// File: dv/omt_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the owned mutex table: watches the request and result channels,
// keeps its own copy of the ownership table and checks every returned status.
// Depends on omt_pkg.
module omt_scoreboard import omt_pkg::*; #(
	parameter int MUTEX_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	output int          mismatches,
	output int          awaited
);

	// Shadow ownership table
	logic        held      [MUTEX_COUNT];
	logic [31:0] held_task [MUTEX_COUNT];
	logic [31:0] held_disp [MUTEX_COUNT];

	// Status codes owed by the block, oldest request first
	status_t status_due [$];
	status_t oldest;

	initial begin
		mismatches = 0;
		awaited = 0;
	end

	function automatic logic owns(int i, logic [31:0] tsk, logic [31:0] dsp);
		return held[i] && held_task[i] == tsk && held_disp[i] == dsp;
	endfunction

	function automatic void free_slot(int i);
		held[i] = 1'b0;
		held_task[i] = '0;
		held_disp[i] = '0;
	endfunction

	// Apply one request to the shadow table and return the status it earns
	function automatic status_t settle_request(op_t op, logic [7:0] id, logic [31:0] tsk,
			logic [31:0] dsp, logic live, logic [6:0] nbytes, logic payload);
		logic bad_id;
		bad_id = (op == OP_CLEANUP) ? (id != 8'd0) : (id >= MUTEX_COUNT);
		if (nbytes != 7'd0 || payload || !live || bad_id)
			return ST_MALFORMED;
		case (op)
			OP_CLEANUP: begin
				for (int i = 0; i < MUTEX_COUNT; i++)
					if (owns(i, tsk, dsp))
						free_slot(i);
				return ST_DONE;
			end
			OP_LOCK: begin
				if (held[id])
					return owns(id, tsk, dsp) ? ST_REENTRANT : ST_BLOCKED;
				held[id] = 1'b1;
				held_task[id] = tsk;
				held_disp[id] = dsp;
				return ST_DONE;
			end
			OP_RELEASE: begin
				if (!owns(id, tsk, dsp))
					return ST_NOT_OWNED;
				free_slot(id);
				return ST_DONE;
			end
			default: return ST_UNSUPPORTED;
		endcase
	endfunction

	task automatic flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Compare returned statuses first, then log the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MUTEX_COUNT; i++)
				free_slot(i);
			status_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					flag($sformatf("status %0d with no request pending", m_tdata[2:0]));
				end else begin
					oldest = status_due.pop_front();
					if (m_tdata[2:0] !== oldest)
						flag($sformatf("status expected %0d, got %0d", oldest, m_tdata[2:0]));
				end
			end
			if (s_tvalid && s_tready)
				status_due = {status_due, settle_request(op_t'(s_tuser), s_tdata[7:0],
					s_tdata[39:8], s_tdata[71:40], s_tdata[72], s_tdata[79:73],
					s_tdata[80])};
		end
		awaited = status_due.size();
	end

endmodule

// File: dv/owned_mutex_table_test.sv
`timescale 1ns / 100ps
// Top of the owned mutex table testbench: clock, reset, request and result
// traffic, and the verdict. Depends on omt_pkg, owned_mutex_table, omt_scoreboard.
module owned_mutex_table_test;
	import omt_pkg::*;

	localparam int MUTEX_COUNT = 16;

	typedef struct packed {
		op_t         op;
		logic [7:0]  id;
		logic [31:0] task_h;
		logic [31:0] disp_h;
		logic        live;
		logic [6:0]  nbytes;
		logic        payload;
	} mutex_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	int          mismatches;
	int          awaited;

	int phase = 0;
	int send_idle_pct = 36;
	int recv_idle_pct = 54;

	// Owners are built from a small pool: three tasks times two dispatches
	logic [31:0] task_pool [3];
	logic [31:0] disp_pool [2];
	int          last_locker [MUTEX_COUNT];

	owned_mutex_table #(.MUTEX_COUNT(MUTEX_COUNT), .HANDLE_BITS(32)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	omt_scoreboard #(.MUTEX_COUNT(MUTEX_COUNT)) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic mutex_req_t make_req(op_t op, logic [7:0] id, int k);
		mutex_req_t r;
		r.op = op;
		r.id = id;
		r.task_h = task_pool[k / 2];
		r.disp_h = disp_pool[k % 2];
		r.live = 1'b1;
		r.nbytes = '0;
		r.payload = 1'b0;
		return r;
	endfunction

	// Mostly well-formed traffic; releases usually come from the last locker
	function automatic mutex_req_t pick_request();
		mutex_req_t r;
		int roll;
		int k;
		int id;
		roll = $urandom_range(99);
		k = $urandom_range(5);
		id = $urandom_range(MUTEX_COUNT - 1);
		if (roll < 45) begin
			r = make_req(OP_LOCK, 8'(id), k);
			last_locker[id] = k;
		end else if (roll < 80) begin
			if ($urandom_range(99) < 70)
				k = last_locker[id];
			r = make_req(OP_RELEASE, 8'(id), k);
		end else if (roll < 93) begin
			r = make_req(OP_CLEANUP, 8'd0, k);
		end else begin
			r = make_req(OP_NONE, 8'(id), k);
		end
		// Corrupt a share of requests
		if ($urandom_range(99) < 15) begin
			case ($urandom_range(5))
				0: r.nbytes = 7'($urandom_range(64, 1));
				1: r.payload = 1'b1;
				2: r.live = 1'b0;
				3: r.id = 8'($urandom_range(255));
				4: begin
					// stranger handles; never let a stranger lock and hog an entry
					r.task_h = $urandom;
					r.disp_h = $urandom;
					if (r.op == OP_LOCK)
						r.op = OP_RELEASE;
				end
				default: begin
					r.op = op_t'(2'($urandom_range(3)));
					r.id = 8'($urandom_range(255));
					r.task_h = $urandom;
					r.disp_h = $urandom;
					r.live = 1'($urandom_range(1));
					r.nbytes = 7'($urandom_range(64));
					r.payload = 1'($urandom_range(1));
				end
			endcase
		end
		return r;
	endfunction

	// Offer one request, idling first at random; leave tvalid high on return
	task automatic offer(mutex_req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 88'({$urandom, $urandom, $urandom});
			s_tuser <= 2'($urandom_range(3));
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, r.payload, r.nbytes, r.live, r.disp_h, r.task_h, r.id};
		s_tuser <= r.op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Result side: random back-pressure, plus one long hold-off in the last phase
	initial begin : result_sink
		logic held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase == 2 && !held_off) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				for (int n = 0; n < 400; n++)
					@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : request_source
		mutex_req_t r;
		for (int i = 0; i < 3; i++)
			task_pool[i] = $urandom;
		for (int i = 0; i < 2; i++)
			disp_pool[i] = $urandom;
		for (int i = 0; i < MUTEX_COUNT; i++)
			last_locker[i] = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ownership rules on one entry: grant, reentry, contention, releases
		offer(make_req(OP_LOCK, 8'd0, 0));
		offer(make_req(OP_LOCK, 8'd0, 0));
		offer(make_req(OP_LOCK, 8'd0, 1));
		offer(make_req(OP_RELEASE, 8'd0, 1));
		offer(make_req(OP_RELEASE, 8'd0, 0));
		offer(make_req(OP_RELEASE, 8'd0, 0));
		// Mutex number bounds and the unsupported operation
		offer(make_req(OP_LOCK, 8'(MUTEX_COUNT - 1), 0));
		offer(make_req(OP_LOCK, 8'(MUTEX_COUNT), 0));
		offer(make_req(OP_LOCK, 8'd255, 0));
		offer(make_req(OP_NONE, 8'd4, 0));
		r = make_req(OP_NONE, 8'd4, 0);
		r.payload = 1'b1;
		offer(r);
		// Malformed fields
		r = make_req(OP_LOCK, 8'd2, 0);
		r.nbytes = 7'd64;
		offer(r);
		r.nbytes = 7'd1;
		offer(r);
		r = make_req(OP_LOCK, 8'd2, 0);
		r.live = 1'b0;
		offer(r);
		offer(make_req(OP_CLEANUP, 8'd1, 0));
		// Cleanup of an owner holding nothing, then of one holding two entries
		offer(make_req(OP_LOCK, 8'd7, 0));
		offer(make_req(OP_LOCK, 8'd3, 2));
		offer(make_req(OP_CLEANUP, 8'd0, 1));
		offer(make_req(OP_CLEANUP, 8'd0, 0));
		offer(make_req(OP_LOCK, 8'(MUTEX_COUNT - 1), 2));
		// Handle extremes: all zeros and all ones
		r = make_req(OP_LOCK, 8'd5, 0);
		r.task_h = '0;
		r.disp_h = '0;
		offer(r);
		r = make_req(OP_LOCK, 8'd6, 0);
		r.task_h = '1;
		r.disp_h = '1;
		offer(r);
		r.op = OP_CLEANUP;
		r.id = 8'd0;
		offer(r);
		r = make_req(OP_RELEASE, 8'd5, 0);
		r.task_h = '0;
		r.disp_h = '0;
		offer(r);
		offer(make_req(OP_CLEANUP, 8'd0, 2));

		// Random traffic in three idling phases
		for (int p = 0; p < 3; p++) begin
			phase = p;
			send_idle_pct = (p == 0) ? 36 : (p == 1) ? 54 : 0;
			recv_idle_pct = (p == 0) ? 54 : (p == 1) ? 36 : 0;
			for (int n = 0; n < 300; n++)
				offer(pick_request());
		end
		s_tvalid <= 1'b0;

		// Drain, then allow the row latency for anything stray
		@(negedge clk);
		while (awaited != 0)
			@(negedge clk);
		repeat (MUTEX_COUNT + 4) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
